FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define MFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Check on every clock edge, reset included.
`define MFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define MFT_ASSERT(lbl, prop)
`define MFT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/mft_pkg.sv
`default_nettype none

package mft_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_AU_MODE       = 3'd0,
    CFG_AU_SHIFT      = 3'd1,
    CFG_AU_FLAGS      = 3'd2,
    CFG_OPERAND_SIZES = 3'd3,
    CFG_OFFSET_VALUE  = 3'd4,
    CFG_SCALE_VALUE   = 3'd5,
    CFG_BIN_THRESHOLD = 3'd6,
    CFG_COUNT_CONTROL = 3'd7
  } cfg_idx_e;

  // Arithmetic formulas (A, B operands, O offset, S scale)
  typedef enum logic [3:0] {
    MODE_AB        = 4'd0,
    MODE_AB_OFS    = 4'd1,
    MODE_ACC_AB    = 4'd2,
    MODE_AA        = 4'd3,
    MODE_AA_ADD_B  = 4'd4,
    MODE_AA_SUB_B  = 4'd5,
    MODE_ACC_AA    = 4'd6,
    MODE_AA_OFS    = 4'd7,
    MODE_AS        = 4'd8,
    MODE_AS_ADD_B  = 4'd9,
    MODE_AS_SUB_B  = 4'd10,
    MODE_AS_OFS    = 4'd11,
    MODE_ACC_AS    = 4'd12,
    MODE_ADD       = 4'd13,
    MODE_SUB       = 4'd14,
    MODE_A_OFS     = 4'd15
  } au_mode_e;

  // Bits of au_flags
  localparam int unsigned FLAG_SIGNED = 0;
  localparam int unsigned FLAG_BYPASS = 1;
  localparam int unsigned FLAG_THR_ONLY = 3;
  localparam logic [1:0] PATH_ARITH_THR = 2'd1;

  // Operand size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  // Bits of count_control
  localparam int unsigned CNT_ENABLE = 15;
  localparam int unsigned CNT_TARGET_W = 15;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        cmd;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] au_value;
    logic               above_threshold;
    logic               count_reached;
    logic [31:0]        hit_count;
  } out_t;

  typedef struct packed {
    au_mode_e    au_mode;
    logic [4:0]  au_shift;
    logic [3:0]  au_flags;
    logic [5:0]  op_sizes;
    logic [31:0] offset_value;
    logic [31:0] scale_value;
    logic [31:0] bin_threshold;
    logic [15:0] count_ctrl;
  } cfg_t;

  // Classified word: result = (acc_use ? acc : 0) + mul_x * mul_y + addend
  typedef struct packed {
    logic        clr;
    logic        thr_only;
    logic        do_thr;
    logic        acc_use;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [31:0] addend;
    logic [31:0] raw_a;
  } q_entry_t;

  // Narrow to byte, halfword or word, then sign- or zero-extend
  function automatic logic [31:0] ext_operand(logic [31:0] raw, logic [1:0] size,
                                              logic sgn);
    logic [31:0] v;
    unique case (size)
      SZ_BYTE: v = sgn ? {{24{raw[7]}}, raw[7:0]} : {24'b0, raw[7:0]};
      SZ_HALF: v = sgn ? {{16{raw[15]}}, raw[15:0]} : {16'b0, raw[15:0]};
      default: v = raw;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mac_filter_threshold_counter_unit.sv
// Registers from input to output: queue, multiply, accumulate and shift, result.
// Throughput: one word per cycle when not stalled; acc_q alone closes the add loop.
// A receiver stall backs the stages up; the queue takes two more words, so five
// words are in flight before in_ready_o drops.
// Reset: rst_ni asynchronous active low; clears configuration, accumulator,
// hit count, queue and all valid flags. No clearing pass.
`default_nettype none

module mac_filter_threshold_counter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mft_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mft_pkg::out_t out_data_o
);
  import mft_pkg::*;

  cfg_t     cfg_q;
  q_entry_t push_entry;
  q_entry_t pop_entry;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AU_MODE:       cfg_q.au_mode       <= au_mode_e'(cfg_data_i[3:0]);
        CFG_AU_SHIFT:      cfg_q.au_shift      <= cfg_data_i[4:0];
        CFG_AU_FLAGS:      cfg_q.au_flags      <= cfg_data_i[3:0];
        CFG_OPERAND_SIZES: cfg_q.op_sizes      <= cfg_data_i[5:0];
        CFG_OFFSET_VALUE:  cfg_q.offset_value  <= cfg_data_i;
        CFG_SCALE_VALUE:   cfg_q.scale_value   <= cfg_data_i;
        CFG_BIN_THRESHOLD: cfg_q.bin_threshold <= cfg_data_i;
        CFG_COUNT_CONTROL: cfg_q.count_ctrl    <= cfg_data_i[15:0];
        default:           cfg_q.count_ctrl    <= cfg_q.count_ctrl;
      endcase
    end
  end

  mft_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  mft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  mft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mft_front.sv
`default_nettype none

module mft_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mft_pkg::in_t      in_data_i,
  input  mft_pkg::cfg_t     cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output mft_pkg::q_entry_t entry_o
);
  import mft_pkg::*;

  logic        sgn;
  logic [31:0] a_ext;
  logic [31:0] b_ext;
  logic [31:0] b_neg;

  // Take a word whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Extend operands
  assign sgn   = cfg_i.au_flags[FLAG_SIGNED];
  assign a_ext = ext_operand(in_data_i.op_a, cfg_i.op_sizes[1:0], sgn);
  assign b_ext = ext_operand(in_data_i.op_b, cfg_i.op_sizes[3:2], sgn);
  assign b_neg = 32'd0 - b_ext;

  // Map the formula onto multiply, addend and accumulate selects
  always_comb begin
    entry_o          = '0;
    entry_o.clr      = !in_data_i.cmd;
    entry_o.thr_only = cfg_i.au_flags[FLAG_THR_ONLY];
    entry_o.do_thr   = cfg_i.au_flags[FLAG_THR_ONLY] ||
                       (cfg_i.au_flags[3:2] == PATH_ARITH_THR);
    entry_o.raw_a    = in_data_i.op_a;
    entry_o.mul_x    = a_ext;
    entry_o.mul_y    = b_ext;
    entry_o.addend   = '0;
    entry_o.acc_use  = 1'b0;
    unique case (cfg_i.au_mode)
      MODE_AB:       entry_o.mul_y = b_ext;
      MODE_AB_OFS:   entry_o.addend = cfg_i.offset_value;
      MODE_ACC_AB:   entry_o.acc_use = 1'b1;
      MODE_AA:       entry_o.mul_y = a_ext;
      MODE_AA_ADD_B: begin
        entry_o.mul_y  = a_ext;
        entry_o.addend = b_ext;
      end
      MODE_AA_SUB_B: begin
        entry_o.mul_y  = a_ext;
        entry_o.addend = b_neg;
      end
      MODE_ACC_AA: begin
        entry_o.mul_y   = a_ext;
        entry_o.acc_use = 1'b1;
      end
      MODE_AA_OFS: begin
        entry_o.mul_y  = a_ext;
        entry_o.addend = cfg_i.offset_value;
      end
      MODE_AS:       entry_o.mul_y = cfg_i.scale_value;
      MODE_AS_ADD_B: begin
        entry_o.mul_y  = cfg_i.scale_value;
        entry_o.addend = b_ext;
      end
      MODE_AS_SUB_B: begin
        entry_o.mul_y  = cfg_i.scale_value;
        entry_o.addend = b_neg;
      end
      MODE_AS_OFS: begin
        entry_o.mul_y  = cfg_i.scale_value;
        entry_o.addend = cfg_i.offset_value;
      end
      MODE_ACC_AS: begin
        entry_o.mul_y   = cfg_i.scale_value;
        entry_o.acc_use = 1'b1;
      end
      MODE_ADD: begin
        entry_o.mul_y  = 32'd1;
        entry_o.addend = b_ext;
      end
      MODE_SUB: begin
        entry_o.mul_y  = 32'd1;
        entry_o.addend = b_neg;
      end
      MODE_A_OFS: begin
        entry_o.mul_y  = 32'd1;
        entry_o.addend = cfg_i.offset_value;
      end
      default: entry_o.mul_y = b_ext;
    endcase
    // Bypass passes extended A through to the shift
    if (cfg_i.au_flags[FLAG_BYPASS]) begin
      entry_o.mul_y   = 32'd1;
      entry_o.addend  = '0;
      entry_o.acc_use = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mft_queue.sv
`default_nettype none
`include "assert_macros.svh"

module mft_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mft_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mft_pkg::q_entry_t entry_o
);
  import mft_pkg::*;

  q_entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `MFT_ASSERT_ALWAYS(a_count_bound, count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `MFT_ASSERT(a_empty_ptrs, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
  `MFT_ASSERT(a_push_grows, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

FILE: rtl/mft_back.sv
`default_nettype none
`include "assert_macros.svh"

module mft_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mft_pkg::cfg_t     cfg_i,
  input  logic              q_valid_i,
  input  mft_pkg::q_entry_t q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mft_pkg::out_t     out_data_o
);
  import mft_pkg::*;

  typedef struct packed {
    logic        clr;
    logic        thr_only;
    logic        do_thr;
    logic        acc_use;
    logic [31:0] prod;
    logic [31:0] addend;
    logic [31:0] raw_a;
  } mul_stage_t;

  typedef struct packed {
    logic        clr;
    logic        do_thr;
    logic [31:0] value;
  } acc_stage_t;

  mul_stage_t  s1_q;
  acc_stage_t  s2_q, s2_d;
  out_t        out_q, out_d;
  logic        s1_v_q, s2_v_q, out_v_q;
  logic [31:0] acc_q, acc_d;
  logic [31:0] hits_q, hits_d;
  logic        s1_acc, s2_acc, s3_acc;
  logic        ld2, ld3;
  logic [31:0] prod;
  logic [31:0] sum;
  logic [31:0] th_in;
  logic [31:0] hits_inc;
  logic [31:0] cnt_target;
  logic        counted;

  // Stage handshakes: each stage takes a word when empty or moving on
  assign s3_acc  = !out_v_q || out_ready_i;
  assign ld3     = s2_v_q && s3_acc;
  assign s2_acc  = !s2_v_q || s3_acc;
  assign ld2     = s1_v_q && s2_acc;
  assign s1_acc  = !s1_v_q || s2_acc;
  assign q_pop_o = q_valid_i && s1_acc;

  // Multiply stage
  assign prod = q_entry_i.mul_x * q_entry_i.mul_y;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q.clr      <= q_entry_i.clr;
      s1_q.thr_only <= q_entry_i.thr_only;
      s1_q.do_thr   <= q_entry_i.do_thr;
      s1_q.acc_use  <= q_entry_i.acc_use;
      s1_q.prod     <= prod;
      s1_q.addend   <= q_entry_i.addend;
      s1_q.raw_a    <= q_entry_i.raw_a;
    end
  end

  // Accumulate and shift stage
  always_comb begin
    sum = (s1_q.acc_use ? acc_q : 32'd0) + s1_q.prod + s1_q.addend;
    if (s1_q.clr) begin
      acc_d = '0;
    end else if (s1_q.thr_only) begin
      acc_d = acc_q;
    end else begin
      acc_d = sum;
    end
    s2_d.clr    = s1_q.clr;
    s2_d.do_thr = s1_q.do_thr;
    s2_d.value  = s1_q.thr_only ? s1_q.raw_a : 32'($signed(sum) >>> cfg_i.au_shift);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_q <= s2_d;
    end
  end

  // Threshold count and result stage
  assign th_in      = ext_operand(s2_q.value, cfg_i.op_sizes[5:4],
                                  cfg_i.au_flags[FLAG_SIGNED]);
  assign hits_inc   = hits_q + 32'd1;
  assign cnt_target = {{(32 - CNT_TARGET_W){1'b0}}, cfg_i.count_ctrl[CNT_TARGET_W-1:0]};
  assign counted    = s2_q.do_thr && cfg_i.count_ctrl[CNT_ENABLE] &&
                      ($signed(th_in) > $signed(cfg_i.bin_threshold));

  always_comb begin
    out_d  = '0;
    hits_d = hits_q;
    if (s2_q.clr) begin
      hits_d = '0;
    end else begin
      if (counted) begin
        hits_d = hits_inc;
      end
      out_d.au_value        = s2_q.value;
      out_d.above_threshold = s2_q.do_thr && (s2_q.value > cfg_i.bin_threshold);
      out_d.count_reached   = counted && (hits_inc == cnt_target);
      out_d.hit_count       = hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      out_q <= out_d;
    end
  end

  // Hold control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      acc_q   <= '0;
      hits_q  <= '0;
    end else begin
      s1_v_q  <= q_pop_o || (s1_v_q && !ld2);
      s2_v_q  <= ld2 || (s2_v_q && !ld3);
      out_v_q <= ld3 || (out_v_q && !out_ready_i);
      if (ld2) begin
        acc_q <= acc_d;
      end
      if (ld3) begin
        hits_q <= hits_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `MFT_ASSERT(a_thr_only_keeps_acc, (ld2 && s1_q.thr_only && !s1_q.clr) |=> $stable(acc_q))
  `MFT_ASSERT(a_clear_zeroes_hits, (ld3 && s2_q.clr) |=> (hits_q == '0 && out_q.hit_count == '0))
  `MFT_ASSERT(a_reached_at_target, (out_v_q && out_q.count_reached) |-> (out_q.hit_count == cnt_target))

endmodule

`default_nettype wire

FILE: sim/tb_mac_filter_threshold_counter_unit.sv
module tb_mac_filter_threshold_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mft_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 1350;
  localparam int unsigned CALM_FROM     = 1200;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_GUARD   = 5000;
  localparam int unsigned PRINT_CAP     = 100;

  // One row of the directed table: a register write or a sample word
  typedef struct packed {
    logic        is_reg;
    cfg_idx_e    reg_idx;
    logic [31:0] reg_word;
    in_t         word;
    logic        typed;
    out_t        want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  // Register shadows and filter state as the block should hold them
  au_mode_e    mode_r;
  logic [4:0]  shift_r;
  logic [3:0]  flags_r;
  logic [5:0]  sizes_r;
  logic [31:0] offset_r;
  logic [31:0] scale_r;
  logic [31:0] thresh_r;
  logic [15:0] cnt_ctrl_r;
  logic [31:0] acc_shadow;
  logic [31:0] hits_shadow;

  out_t        filter_out_q[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatch_cnt;
  int unsigned words_sent;
  logic        calm;

  mac_filter_threshold_counter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Narrow to byte or halfword, sign-extend when signed and zero-extend when unsigned
  function automatic logic [31:0] widen(logic [31:0] raw, logic [1:0] size, logic sgn);
    if (size == SZ_BYTE) return {{24{sgn & raw[7]}}, raw[7:0]};
    if (size == SZ_HALF) return {{16{sgn & raw[15]}}, raw[15:0]};
    return raw;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] d);
    case (idx)
      CFG_AU_MODE:       mode_r = au_mode_e'(d[3:0]);
      CFG_AU_SHIFT:      shift_r = d[4:0];
      CFG_AU_FLAGS:      flags_r = d[3:0];
      CFG_OPERAND_SIZES: sizes_r = d[5:0];
      CFG_OFFSET_VALUE:  offset_r = d;
      CFG_SCALE_VALUE:   scale_r = d;
      CFG_BIN_THRESHOLD: thresh_r = d;
      default:           cnt_ctrl_r = d[15:0];
    endcase
  endfunction

  // Compute the filter output for one sample word and advance the state
  function automatic out_t compute_filter_out(in_t w);
    out_t        r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] acc;
    logic [31:0] val;
    logic [31:0] th;
    logic        sgn;
    logic        thr_only;
    logic        do_thr;
    r = '0;
    if (!w.cmd) begin
      acc_shadow = '0;
      hits_shadow = '0;
      return r;
    end
    sgn = flags_r[FLAG_SIGNED];
    thr_only = flags_r[FLAG_THR_ONLY];
    do_thr = thr_only || (flags_r[3:2] == PATH_ARITH_THR);
    if (thr_only) begin
      val = w.op_a;
    end else begin
      a = widen(w.op_a, sizes_r[1:0], sgn);
      b = widen(w.op_b, sizes_r[3:2], sgn);
      case (mode_r)
        MODE_AB:       acc = a * b;
        MODE_AB_OFS:   acc = a * b + offset_r;
        MODE_ACC_AB:   acc = acc_shadow + a * b;
        MODE_AA:       acc = a * a;
        MODE_AA_ADD_B: acc = a * a + b;
        MODE_AA_SUB_B: acc = a * a - b;
        MODE_ACC_AA:   acc = acc_shadow + a * a;
        MODE_AA_OFS:   acc = a * a + offset_r;
        MODE_AS:       acc = a * scale_r;
        MODE_AS_ADD_B: acc = a * scale_r + b;
        MODE_AS_SUB_B: acc = a * scale_r - b;
        MODE_AS_OFS:   acc = a * scale_r + offset_r;
        MODE_ACC_AS:   acc = acc_shadow + a * scale_r;
        MODE_ADD:      acc = a + b;
        MODE_SUB:      acc = a - b;
        default:       acc = a + offset_r;
      endcase
      if (flags_r[FLAG_BYPASS]) acc = a;
      acc_shadow = acc;
      val = $signed(acc) >>> shift_r;
    end
    // Count against the signed threshold, flag against the unsigned one
    if (do_thr) begin
      th = widen(val, sizes_r[5:4], sgn);
      if (cnt_ctrl_r[CNT_ENABLE] && ($signed(th) > $signed(thresh_r))) begin
        hits_shadow = hits_shadow + 32'd1;
        if (hits_shadow == {17'b0, cnt_ctrl_r[CNT_TARGET_W-1:0]}) r.count_reached = 1'b1;
      end
      r.above_threshold = (val > thresh_r);
    end
    r.au_value = val;
    r.hit_count = hits_shadow;
    return r;
  endfunction

  function automatic in_t mk_word(logic cmd, logic [31:0] a, logic [31:0] b);
    in_t w;
    w.cmd = cmd;
    w.op_a = a;
    w.op_b = b;
    return w;
  endfunction

  function automatic out_t mk_out(logic [31:0] v, logic above, logic reached, logic [31:0] hits);
    out_t r;
    r.au_value = v;
    r.above_threshold = above;
    r.count_reached = reached;
    r.hit_count = hits;
    return r;
  endfunction

  function automatic void add_reg(cfg_idx_e idx, logic [31:0] d);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_word = d;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_word(in_t w, logic typed, out_t want);
    stim_row_t row;
    row = '0;
    row.word = w;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endfunction

  // Mix of extremes, small magnitudes of either sign, and full random words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'h7FFF_FFFF;
          3:       return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1:       return $urandom_range(0, 300);
      2:       return ~$urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  // Hold the sender and let the pipeline empty before touching registers
  task automatic settle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (filter_out_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drive one register write, then leave the channel idle
  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic send_word(in_t w, logic typed, out_t want);
    out_t exp;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    exp = compute_filter_out(w);
    if (typed) exp = want;
    filter_out_q.push_back(exp);
    words_sent++;
  endtask

  // Stop sending until every pending result is back
  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (filter_out_q.size() != 0);
  endtask

  task automatic randomize_regs(logic all_regs);
    logic [31:0] d;
    for (int i = 0; i < 8; i++) begin
      if (all_regs || $urandom_range(0, 1) == 1) begin
        d = $urandom;
        case (cfg_idx_e'(i))
          CFG_AU_SHIFT: begin
            if ($urandom_range(0, 3) == 0) d[4:0] = 5'd0;
            else if ($urandom_range(0, 3) == 0) d[4:0] = 5'd31;
            else d[4:0] = 5'($urandom_range(0, 6));
          end
          CFG_OFFSET_VALUE, CFG_SCALE_VALUE, CFG_BIN_THRESHOLD: d = pick_word();
          CFG_COUNT_CONTROL: begin
            d[CNT_ENABLE] = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
              0:       d[14:0] = 15'h7FFF;
              1:       d[14:0] = 15'($urandom);
              default: d[14:0] = 15'($urandom_range(0, 6));
            endcase
          end
          default: ;
        endcase
        write_reg(cfg_idx_e'(i), d);
      end
    end
  endtask

  task automatic build_table();
    // After reset: unsigned byte product, then the widest raw words
    add_word(mk_word(1'b1, 32'd5, 32'd7), 1'b1, mk_out(32'd35, 1'b0, 1'b0, 32'd0));
    add_word(mk_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
             mk_out(32'd65025, 1'b0, 1'b0, 32'd0));
    add_word(mk_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, '0);
    // Every formula with signed byte A, halfword B and extreme constants
    add_reg(CFG_AU_FLAGS, 32'd1);
    add_reg(CFG_OPERAND_SIZES, {26'd0, 2'd2, SZ_HALF, SZ_BYTE});
    add_reg(CFG_OFFSET_VALUE, 32'h7FFF_FFFF);
    add_reg(CFG_SCALE_VALUE, 32'h8000_0000);
    add_reg(CFG_AU_SHIFT, 32'd3);
    for (int m = 0; m < 16; m++) begin
      add_reg(CFG_AU_MODE, m);
      add_word(mk_word(1'b1, $urandom, $urandom), 1'b0, '0);
    end
    // Bypass passes extended operand A through to the shift
    add_reg(CFG_AU_FLAGS, 32'd3);
    add_word(mk_word(1'b1, 32'hFFFF_8000, 32'h1234_5678), 1'b0, '0);
    // Arith then threshold: count up to a target of two
    add_reg(CFG_AU_MODE, 32'(MODE_ADD));
    add_reg(CFG_AU_SHIFT, 32'd0);
    add_reg(CFG_OPERAND_SIZES, {26'd0, SZ_BYTE, 2'd2, 2'd2});
    add_reg(CFG_BIN_THRESHOLD, 32'hFFFF_FFFB);
    add_reg(CFG_COUNT_CONTROL, 32'h0000_8002);
    add_reg(CFG_AU_FLAGS, 32'd5);
    add_word(mk_word(1'b0, 32'd0, 32'd0), 1'b1, '0);
    add_word(mk_word(1'b1, 32'd10, 32'd0), 1'b0, '0);
    add_word(mk_word(1'b1, 32'd20, 32'd1), 1'b0, '0);
    add_word(mk_word(1'b1, 32'hFFFF_FF00, 32'd0), 1'b0, '0);
    // Threshold only leaves the accumulator alone; path code three acts the same
    add_reg(CFG_AU_FLAGS, 32'd8);
    add_word(mk_word(1'b1, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0);
    add_reg(CFG_COUNT_CONTROL, 32'h0000_7FFF);
    add_reg(CFG_AU_FLAGS, 32'd12);
    add_word(mk_word(1'b1, 32'h7FFF_FFFF, 32'd0), 1'b0, '0);
  endtask

  // Receiver: random stall bursts, none once the run goes calm
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= (stall_left == 0);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filter_out_q.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = filter_out_q.pop_front();
        if (out_data_o.au_value !== want.au_value)
          report_mismatch($sformatf("au_value %h, want %h",
                                    out_data_o.au_value, want.au_value));
        if (out_data_o.above_threshold !== want.above_threshold)
          report_mismatch($sformatf("above_threshold %b, want %b",
                                    out_data_o.above_threshold, want.above_threshold));
        if (out_data_o.count_reached !== want.count_reached)
          report_mismatch($sformatf("count_reached %b, want %b",
                                    out_data_o.count_reached, want.count_reached));
        if (out_data_o.hit_count !== want.hit_count)
          report_mismatch($sformatf("hit_count %h, want %h",
                                    out_data_o.hit_count, want.hit_count));
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int          pause_at;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_AU_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    mismatch_cnt = 0;
    words_sent  = 0;
    mode_r = MODE_AB;
    shift_r = '0;
    flags_r = '0;
    sizes_r = '0;
    offset_r = '0;
    scale_r = '0;
    thresh_r = '0;
    cnt_ctrl_r = '0;
    acc_shadow = '0;
    hits_shadow = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    build_table();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        settle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_word);
      end else begin
        send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases: new settings, often a clear, then a run of samples
    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      calm = (words_sent >= CALM_FROM) || ($urandom_range(0, 4) == 0);
      randomize_regs(phase == 0);
      if ($urandom_range(0, 1) == 1) send_word(mk_word(1'b0, $urandom, $urandom), 1'b0, '0);
      n = $urandom_range(20, 80);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int k = 0; k < n && words_sent < RANDOM_WORDS; k++) begin
        if (k == pause_at) hold_for_results();
        calm = calm || (words_sent >= CALM_FROM);
        send_word(mk_word($urandom_range(0, 24) != 0, pick_word(), pick_word()), 1'b0, '0);
      end
      phase++;
    end

    settle();
    if (filter_out_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", filter_out_q.size()));
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
